@@ rtl/core/timed_event_sorted_queue_assert.svh @@
// Assertion macros used by the timed event queue checker.
`ifndef TIMED_EVENT_SORTED_QUEUE_ASSERT_SVH
`define TIMED_EVENT_SORTED_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define TESQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("timed event queue check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define TESQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("timed event queue check failed");

`endif

@@ rtl/core/tesq_pkg.sv @@
// Package with the command codes, entry and result types of the timed event queue.
package tesq_pkg;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_POP    = 2'd2;

   typedef struct packed {
      logic [31:0] ev_time;
      logic [7:0]  action;
      logic [7:0]  id;
   } entry_type;

   typedef struct packed {
      logic        ok;
      logic [7:0]  out_id;
      logic [31:0] out_time;
      logic [7:0]  out_action;
      logic [7:0]  entry_count;
   } result_type;

endpackage

@@ rtl/core/tesq_mem.sv @@
// Entry memory of the timed event queue: one write port, one registered read port.
module tesq_mem
   import tesq_pkg::*;
#(
   parameter int DEPTH = 255,
   parameter int IW    = 8
) (
   input  logic           clock,
   input  logic           mem_we,
   input  logic [IW-1:0]  mem_waddr,
   input  entry_type      mem_wdata,
   input  logic [IW-1:0]  mem_raddr,
   output entry_type      mem_rdata
);

   entry_type mem_array [DEPTH];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_array[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem_array[mem_raddr];
   end

   assign mem_rdata = rdata_ff;

endmodule

@@ rtl/core/tesq_seq.sv @@
// Sequencer of the timed event queue: walks the entry memory to insert, delete and pop.
module tesq_seq
   import tesq_pkg::*;
#(
   parameter int CAPACITY = 255,
   parameter int IW       = 8,
   parameter int CW       = 8
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic [1:0]     req_command,
   input  logic [31:0]    req_event_time,
   input  logic [7:0]     req_event_action,
   input  logic [7:0]     req_target_id,
   input  logic           out_free,
   output logic           res_valid,
   output result_type     res_data,
   output logic           mem_we,
   output logic [IW-1:0]  mem_waddr,
   output entry_type      mem_wdata,
   output logic [IW-1:0]  mem_raddr,
   input  entry_type      mem_rdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_WALK,
      S_INS_PLACE,
      S_DEL_WALK,
      S_DONE
   } state_type;

   state_type    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]   idctr_ff, idctr_in;
   logic [1:0]   cmd_ff, cmd_in;
   logic [31:0]  time_ff, time_in;
   logic [7:0]   act_ff, act_in;
   logic [7:0]   tid_ff, tid_in;
   logic [IW-1:0] pidx_ff, pidx_in;
   logic         found_ff, found_in;
   result_type   res_ff, res_in;

   entry_type    new_entry;
   logic [CW-1:0] count_dec;
   logic [CW-1:0] count_inc;
   logic         pidx_last;
   logic         match_now;
   logic         found_next;

   assign new_entry  = '{ev_time: time_ff, action: act_ff, id: idctr_ff};
   assign count_dec  = count_ff - 1'b1;
   assign count_inc  = count_ff + 1'b1;
   assign pidx_last  = (CW'(pidx_ff) == count_dec);
   assign match_now  = !found_ff && ((cmd_ff == CMD_POP) || (mem_rdata.id == tid_ff));
   assign found_next = found_ff || match_now;

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res_data  = res_ff;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idctr_in  = idctr_ff;
      cmd_in    = cmd_ff;
      time_in   = time_ff;
      act_in    = act_ff;
      tid_in    = tid_ff;
      pidx_in   = pidx_ff;
      found_in  = found_ff;
      res_in    = res_ff;
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = mem_rdata;
      mem_raddr = '0;

      unique case (state_ff)
         S_IDLE: begin
            // The first read is issued on the accepting edge.
            mem_raddr = (req_command == CMD_INSERT) ? IW'(count_dec) : '0;
            if (req_valid) begin
               cmd_in   = req_command;
               time_in  = req_event_time;
               act_in   = req_event_action;
               tid_in   = req_target_id;
               found_in = 1'b0;
               pidx_in  = (req_command == CMD_INSERT) ? IW'(count_dec) : '0;
               res_in   = '0;
               res_in.entry_count = 8'(count_ff);
               state_in = S_DONE;
               unique case (req_command) inside
                  CMD_INSERT: begin
                     if (count_ff < CW'(CAPACITY)) begin
                        idctr_in = idctr_ff + 8'd1;
                        state_in = (count_ff == '0) ? S_INS_PLACE : S_INS_WALK;
                     end
                  end
                  CMD_DELETE, CMD_POP: begin
                     if (count_ff != '0) begin
                        state_in = S_DEL_WALK;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_INS_WALK: begin
            mem_we    = 1'b1;
            mem_waddr = pidx_ff + 1'b1;
            if (mem_rdata.ev_time >= time_ff) begin
               // Entry moves up one slot; keep walking toward the head.
               mem_wdata = mem_rdata;
               if (pidx_ff == '0) begin
                  state_in = S_INS_PLACE;
               end else begin
                  mem_raddr = pidx_ff - 1'b1;
                  pidx_in   = pidx_ff - 1'b1;
               end
            end else begin
               mem_wdata          = new_entry;
               count_in           = count_inc;
               res_in.ok          = 1'b1;
               res_in.out_id      = idctr_ff;
               res_in.entry_count = 8'(count_inc);
               state_in           = S_DONE;
            end
         end
         S_INS_PLACE: begin
            mem_we             = 1'b1;
            mem_waddr          = '0;
            mem_wdata          = new_entry;
            count_in           = count_inc;
            res_in.ok          = 1'b1;
            res_in.out_id      = idctr_ff;
            res_in.entry_count = 8'(count_inc);
            state_in           = S_DONE;
         end
         S_DEL_WALK: begin
            if (match_now && (cmd_ff == CMD_POP)) begin
               res_in.out_id     = mem_rdata.id;
               res_in.out_time   = mem_rdata.ev_time;
               res_in.out_action = mem_rdata.action;
            end
            if (found_ff) begin
               // Entries behind the removed one move down one slot.
               mem_we    = 1'b1;
               mem_waddr = pidx_ff - 1'b1;
               mem_wdata = mem_rdata;
            end
            if (pidx_last) begin
               if (found_next) begin
                  count_in           = count_dec;
                  res_in.ok          = 1'b1;
                  res_in.entry_count = 8'(count_dec);
               end
               state_in = S_DONE;
            end else begin
               mem_raddr = pidx_ff + 1'b1;
               pidx_in   = pidx_ff + 1'b1;
               found_in  = found_next;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         idctr_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idctr_ff <= idctr_in;
      end
      cmd_ff   <= cmd_in;
      time_ff  <= time_in;
      act_ff   <= act_in;
      tid_ff   <= tid_in;
      pidx_ff  <= pidx_in;
      found_ff <= found_in;
      res_ff   <= res_in;
   end

endmodule

@@ rtl/core/timed_event_sorted_queue.sv @@
// Top level of the timed event queue: sequencer, entry memory and result register.
//
// The queue holds up to CAPACITY timed events in one memory, sorted by time
// ascending. A request transaction on the req_ channel carries a command:
// insert (time and action, returns the new id), delete by id, or pop of the
// earliest event. Every request yields exactly one response transaction on
// the rsp_ channel with a success flag, the id, time and action where they
// apply, and the number of events held afterwards.
// Only one request is worked on at a time. The sequencer walks the memory
// one entry per cycle through its single read port: an insert walks from
// the tail down to its position, a delete or pop walks all held entries,
// and a failed request that needs no walk goes straight to its result. The
// next request can be accepted from the cycle after the sequencer hands its
// result to the output register, even when that result still waits there.
// If the receiver stalls, the result stays in the output register and the
// sequencer holds its next result until the register frees up.
// Reset clears the count, the id counter and all handshake state. The
// memory itself is not cleared: only entries below the count are used.
module timed_event_sorted_queue
   import tesq_pkg::*;
#(
   parameter int CAPACITY = 255
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_event_time,
   input  logic [7:0]  req_event_action,
   input  logic [7:0]  req_target_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_ok,
   output logic [7:0]  rsp_out_id,
   output logic [31:0] rsp_out_time,
   output logic [7:0]  rsp_out_action,
   output logic [7:0]  rsp_entry_count
);

   // Memory index width and count width (the count must reach CAPACITY).
   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   entry_type     mem_wdata;
   logic [IW-1:0] mem_raddr;
   entry_type     mem_rdata;

   logic          res_valid;
   result_type    res_data;
   logic          out_free;

   logic          rsp_valid_ff;
   result_type    rsp_data_ff;

   // The output register can take a new result when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   tesq_seq #(
      .CAPACITY (CAPACITY),
      .IW       (IW),
      .CW       (CW)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_event_time   (req_event_time),
      .req_event_action (req_event_action),
      .req_target_id    (req_target_id),
      .out_free         (out_free),
      .res_valid        (res_valid),
      .res_data         (res_data),
      .mem_we           (mem_we),
      .mem_waddr        (mem_waddr),
      .mem_wdata        (mem_wdata),
      .mem_raddr        (mem_raddr),
      .mem_rdata        (mem_rdata)
   );

   tesq_mem #(
      .DEPTH (CAPACITY),
      .IW    (IW)
   ) u_mem (
      .clock     (clock),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   // Result register between the sequencer and the response channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_valid && out_free) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_data_ff.ok;
   assign rsp_out_id      = rsp_data_ff.out_id;
   assign rsp_out_time    = rsp_data_ff.out_time;
   assign rsp_out_action  = rsp_data_ff.out_action;
   assign rsp_entry_count = rsp_data_ff.entry_count;

endmodule

@@ rtl/core/tesq_checker.sv @@
// Port-level checker of the timed event queue and its bind to the top level.
`include "timed_event_sorted_queue_assert.svh"

module tesq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_ok,
   input logic [7:0]  rsp_out_id,
   input logic [31:0] rsp_out_time,
   input logic [7:0]  rsp_out_action,
   input logic [7:0]  rsp_entry_count
);

   logic        fail_fields_zero;
   logic [56:0] rsp_payload;

   assign fail_fields_zero = (rsp_out_id == 8'd0) && (rsp_out_time == 32'd0)
                             && (rsp_out_action == 8'd0);
   assign rsp_payload = {rsp_ok, rsp_out_id, rsp_out_time, rsp_out_action, rsp_entry_count};

   // A failed request reports no id, time or action.
   `TESQ_ASSERT_NOW(a_fail_fields_zero, rsp_valid && !rsp_ok, fail_fields_zero)

   // Only one request is in flight: ready drops right after acceptance.
   `TESQ_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)

   // A stalled response stays valid.
   `TESQ_ASSERT_NEXT(a_rsp_hold_valid, rsp_valid && !rsp_ready, rsp_valid)

   // A stalled response keeps its payload.
   `TESQ_ASSERT_NEXT(a_rsp_hold_data, rsp_valid && !rsp_ready, $stable(rsp_payload))

endmodule

bind timed_event_sorted_queue tesq_checker u_tesq_checker (.*);
